// File: sv/c3cf_pkg.sv
`default_nettype none
package c3cf_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ROW_W  = 17;  // row count runs up to height+1
  localparam int unsigned HGT_W  = 16;
  localparam int unsigned IMW_W  = 11;
  localparam int unsigned MASK_W = 24;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ACC_W  = 20;  // 9 * 255 * 128 fits in 20 signed bits
  localparam int unsigned TAPS   = 9;
  localparam int unsigned DIV_STEPS = ACC_W;

  localparam logic [IDX_W-1:0] CFG_MASK_TOP    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_MASK_MIDDLE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MASK_BOTTOM = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DIVISOR     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_IMG_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd5;

  localparam logic [0:0] OP_PIXEL = 1'b0;
  localparam logic [0:0] OP_DRAIN = 1'b1;

  typedef struct packed {
    logic capture;
    logic adv;
    logic zero_pix;
    logic mac_start;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic res_div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic row_lt_h;
    logic pend_nz;
    logic have;
    logic filt;
    logic mac_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/c3cf_in_if.sv
`default_nettype none
interface c3cf_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] opcode;
  logic [7:0] pixel_in;
  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface
`default_nettype wire

// File: sv/c3cf_out_if.sv
`default_nettype none
interface c3cf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [0:0] last_pixel;
  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface
`default_nettype wire

// File: sv/c3cf_ram.sv
`default_nettype none
module c3cf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/c3cf_dp.sv
`default_nettype none
module c3cf_dp #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire c3cf_pkg::cmd_t                  cmd_i,
  output c3cf_pkg::sts_t                       sts_o,
  input  wire logic [0:0]                      opcode_i,
  input  wire logic [c3cf_pkg::PIX_W-1:0]      pixel_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [c3cf_pkg::IDX_W-1:0]      cfg_idx_i,
  input  wire logic [c3cf_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic      [c3cf_pkg::PIX_W-1:0]      out_pixel_o,
  output logic      [0:0]                      out_last_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 3);
  localparam int unsigned RW = c3cf_pkg::ROW_W;
  localparam int unsigned CNT_W = $clog2(c3cf_pkg::DIV_STEPS);
  localparam int unsigned W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // configuration
  logic [c3cf_pkg::MASK_W-1:0] mask_q [3];
  logic [c3cf_pkg::DIV_W-1:0]  div_q;
  logic [c3cf_pkg::IMW_W-1:0]  imw_q;
  logic [c3cf_pkg::HGT_W-1:0]  imh_q;

  // geometry and position
  logic [WW-1:0]               cur_w_q;
  logic [c3cf_pkg::HGT_W-1:0]  cur_h_q;
  logic [AW-1:0]               col_q;
  logic [RW-1:0]               row_q;
  logic [PW-1:0]               pend_q;
  logic [0:0]                  op_q;
  logic [c3cf_pkg::PIX_W-1:0]  pix_q;
  logic [c3cf_pkg::PIX_W-1:0]  win_q [3][3];

  // line stores
  logic [c3cf_pkg::PIX_W-1:0]  up_rd, lo_rd, pix_eff;

  // arithmetic
  logic [3:0]                  mac_idx_q;
  logic signed [c3cf_pkg::ACC_W-1:0] acc_q;
  logic [c3cf_pkg::ACC_W-1:0]  qd_q;
  logic [c3cf_pkg::DIV_W-1:0]  rem_q;
  logic [c3cf_pkg::DIV_W-1:0]  dmag_q;
  logic                        qneg_q;
  logic [CNT_W-1:0]            dcnt_q;

  logic [c3cf_pkg::PIX_W-1:0]  res_q;
  logic                        res_last_q;
  logic                        out_valid_q;
  logic [c3cf_pkg::PIX_W-1:0]  out_pix_q;
  logic                        out_last_q;

  logic                        ic_zero, have, filt, last, wrap, out_free;
  logic [PW-1:0]               pend_inc;
  logic [c3cf_pkg::PIX_W-1:0]  mac_pix;
  logic [7:0]                  mac_coef;
  logic signed [16:0]          prod;
  logic [c3cf_pkg::DIV_W-1:0]  dv;
  logic [c3cf_pkg::DIV_W:0]    trial;
  logic                        fire;
  logic [WW-1:0]               w_sat;
  logic [c3cf_pkg::HGT_W-1:0]  h_sat;

  assign pix_eff = cmd_i.zero_pix ? '0 : pix_q;

  c3cf_ram #(.WIDTH(c3cf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.adv),
    .addr_i  (col_q),
    .wdata_i (lo_rd),
    .rdata_o (up_rd)
  );

  c3cf_ram #(.WIDTH(c3cf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (cmd_i.adv),
    .addr_i  (col_q),
    .wdata_i (pix_eff),
    .rdata_o (lo_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q[0] <= '0;
      mask_q[1] <= 24'd256;
      mask_q[2] <= '0;
      div_q     <= 16'd1;
      imw_q     <= 11'd1024;
      imh_q     <= 16'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c3cf_pkg::CFG_MASK_TOP:    mask_q[0] <= cfg_data_i;
        c3cf_pkg::CFG_MASK_MIDDLE: mask_q[1] <= cfg_data_i;
        c3cf_pkg::CFG_MASK_BOTTOM: mask_q[2] <= cfg_data_i;
        c3cf_pkg::CFG_DIVISOR:     div_q <= cfg_data_i[c3cf_pkg::DIV_W-1:0];
        c3cf_pkg::CFG_IMG_WIDTH:   imw_q <= cfg_data_i[c3cf_pkg::IMW_W-1:0];
        c3cf_pkg::CFG_IMG_HEIGHT:  imh_q <= cfg_data_i[c3cf_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry clamp
  always_comb begin
    if (imw_q == '0) begin
      w_sat = WW'(1);
    end else if (32'(imw_q) > 32'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(imw_q);
    end
    h_sat = (imh_q == '0) ? c3cf_pkg::HGT_W'(1) : imh_q;
  end

  // output decode for the current position, before it advances
  always_comb begin
    ic_zero  = (col_q == '0);
    have     = ic_zero ? (row_q >= RW'(2)) : (row_q >= RW'(1));
    filt     = !ic_zero && (row_q >= RW'(2)) && (row_q < {1'b0, cur_h_q})
               && (col_q >= AW'(2));
    last     = ic_zero && (row_q == ({1'b0, cur_h_q} + RW'(1)));
    wrap     = (32'(col_q) + 32'd1) >= 32'(cur_w_q);
    pend_inc = pend_q + (cmd_i.zero_pix ? PW'(0) : PW'(1));
  end

  assign fire = cmd_i.capture && (opcode_i == c3cf_pkg::OP_PIXEL) && (row_q == '0)
                && (col_q == '0) && (pend_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q <= WW'(W_RST);
      cur_h_q <= 16'd1024;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (fire) begin
        cur_w_q <= w_sat;
        cur_h_q <= h_sat;
      end
      if (cmd_i.adv) begin
        win_q[0][0] <= win_q[0][1];
        win_q[0][1] <= win_q[0][2];
        win_q[0][2] <= up_rd;
        win_q[1][0] <= win_q[1][1];
        win_q[1][1] <= win_q[1][2];
        win_q[1][2] <= lo_rd;
        win_q[2][0] <= win_q[2][1];
        win_q[2][1] <= win_q[2][2];
        win_q[2][2] <= pix_eff;
        if (last) begin
          col_q  <= '0;
          row_q  <= '0;
          pend_q <= '0;
        end else begin
          if (wrap) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + AW'(1);
          end
          pend_q <= (have && pend_inc != '0) ? pend_inc - PW'(1) : pend_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      pix_q <= pixel_i;
    end
  end

  // sequential multiply-accumulate over the nine taps
  always_comb begin
    case (mac_idx_q)
      4'd0: begin mac_pix = win_q[0][0]; mac_coef = mask_q[0][7:0];   end
      4'd1: begin mac_pix = win_q[0][1]; mac_coef = mask_q[0][15:8];  end
      4'd2: begin mac_pix = win_q[0][2]; mac_coef = mask_q[0][23:16]; end
      4'd3: begin mac_pix = win_q[1][0]; mac_coef = mask_q[1][7:0];   end
      4'd4: begin mac_pix = win_q[1][1]; mac_coef = mask_q[1][15:8];  end
      4'd5: begin mac_pix = win_q[1][2]; mac_coef = mask_q[1][23:16]; end
      4'd6: begin mac_pix = win_q[2][0]; mac_coef = mask_q[2][7:0];   end
      4'd7: begin mac_pix = win_q[2][1]; mac_coef = mask_q[2][15:8];  end
      4'd8: begin mac_pix = win_q[2][2]; mac_coef = mask_q[2][23:16]; end
      default: begin mac_pix = '0; mac_coef = '0; end
    endcase
    prod  = $signed({1'b0, mac_pix}) * $signed(mac_coef);
    dv    = (div_q == '0) ? c3cf_pkg::DIV_W'(1) : div_q;
    trial = {rem_q, qd_q[c3cf_pkg::ACC_W-1]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_start) begin
      acc_q     <= '0;
      mac_idx_q <= '0;
    end else if (cmd_i.mac_step) begin
      acc_q     <= acc_q + {{(c3cf_pkg::ACC_W-17){prod[16]}}, prod};
      mac_idx_q <= mac_idx_q + 4'd1;
    end
    if (cmd_i.div_start) begin
      dmag_q <= dv[c3cf_pkg::DIV_W-1] ? (~dv + c3cf_pkg::DIV_W'(1)) : dv;
      qd_q   <= acc_q[c3cf_pkg::ACC_W-1] ? c3cf_pkg::ACC_W'(-acc_q)
                                         : c3cf_pkg::ACC_W'(acc_q);
      qneg_q <= acc_q[c3cf_pkg::ACC_W-1] ^ dv[c3cf_pkg::DIV_W-1];
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      // restoring step: one quotient bit per cycle
      if (trial >= {1'b0, dmag_q}) begin
        rem_q <= c3cf_pkg::DIV_W'(trial - {1'b0, dmag_q});
        qd_q  <= {qd_q[c3cf_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[c3cf_pkg::DIV_W-1:0];
        qd_q  <= {qd_q[c3cf_pkg::ACC_W-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q + CNT_W'(1);
    end
    if (cmd_i.adv) begin
      res_q      <= win_q[1][2];  // pass-through value is the cell that moves to center
      res_last_q <= last;
    end else if (cmd_i.res_div) begin
      if (qneg_q) begin
        res_q <= '0;
      end else if (qd_q > c3cf_pkg::ACC_W'(255)) begin
        res_q <= 8'd255;
      end else begin
        res_q <= qd_q[c3cf_pkg::PIX_W-1:0];
      end
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pix_q  <= res_q;
      out_last_q <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pix_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o.op       = op_q[0];
    sts_o.row_lt_h = row_q < {1'b0, cur_h_q};
    sts_o.pend_nz  = (pend_q != '0);
    sts_o.have     = have;
    sts_o.filt     = filt;
    sts_o.mac_last = (mac_idx_q == 4'(c3cf_pkg::TAPS - 1));
    sts_o.div_last = (dcnt_q == CNT_W'(c3cf_pkg::DIV_STEPS - 1));
    sts_o.out_free = out_free;
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.adv && last) |=> (row_q == '0 && col_q == '0 && pend_q == '0))
    else $error("position not cleared after last word");
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(cur_w_q))
    else $error("column beyond latched width");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("output register overwritten");
`endif

endmodule
`default_nettype wire

// File: sv/c3cf_ctrl.sv
`default_nettype none
module c3cf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire c3cf_pkg::sts_t sts_i,
  output c3cf_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DEC  = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_ADV  = 4'd3;
  localparam logic [3:0] ST_MAC  = 4'd4;
  localparam logic [3:0] ST_DVL  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       drain_q, drain_d;
  logic       try_q, try_d;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    try_d   = try_q;
    cmd_o   = '0;
    cmd_o.zero_pix = drain_q;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        try_d = 1'b0;
        if (sts_i.row_lt_h) begin
          drain_d = 1'b0;
          state_d = sts_i.op ? ST_IDLE : ST_RD;
        end else if (sts_i.pend_nz) begin
          drain_d = 1'b1;
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_ADV;
      end
      ST_ADV: begin
        cmd_o.adv       = 1'b1;
        cmd_o.mac_start = 1'b1;
        if (sts_i.have) begin
          state_d = sts_i.filt ? ST_MAC : ST_OUT;
        end else if (drain_q && !try_q) begin
          try_d   = 1'b1;
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_last) begin
          state_d = ST_DVL;
        end
      end
      ST_DVL: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.res_div = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= 1'b0;
      try_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      try_q   <= try_d;
    end
  end

`ifndef SYNTHESIS
  a_filt_to_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV && sts_i.have && sts_i.filt) |=> (state_q == ST_MAC))
    else $error("interior pixel skipped the filter");
`endif

endmodule
`default_nettype wire

// File: sv/conv3x3_clamp_filter.sv
// channel | dir | handshake     | word
// in_s    | in  | valid/ready   | opcode[0:0], pixel_in[7:0]
// out_s   | out | valid/ready   | pixel_out[7:0], last_pixel[0:0]
// cfg     | in  | cfg_we_i only | cfg_idx_i[2:0], cfg_data_i[23:0]
//
// One input word at a time. A filtered pixel runs nine taps through one
// shared multiplier, then a 20-step radix-2 divider; border and pass-through
// pixels skip both. A drain word may run the line-store path twice.
// Async active-low reset returns position, geometry and config to defaults;
// the line stores are not cleared.
// A full output register holds the controller in its output state.
`default_nettype none
module conv3x3_clamp_filter #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  c3cf_in_if.sink                            in_s,
  c3cf_out_if.source                         out_s,
  input  wire logic                          cfg_we_i,
  input  wire logic [c3cf_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [c3cf_pkg::CFG_W-1:0]    cfg_data_i
);

  c3cf_pkg::cmd_t cmd;
  c3cf_pkg::sts_t sts;
  logic           in_ready;

  // controller: sequences read, advance, MAC, divide, output load
  c3cf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_s.ready = in_ready;

  // datapath: line stores, window, arithmetic, output register
  c3cf_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (in_s.opcode),
    .pixel_i     (in_s.pixel_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_s.ready),
    .out_valid_o (out_s.valid),
    .out_pixel_o (out_s.pixel_out),
    .out_last_o  (out_s.last_pixel)
  );

endmodule
`default_nettype wire

// File: dv/tb_conv3x3_clamp_filter.sv
`timescale 1ns / 1ps
module tb_conv3x3_clamp_filter;

  localparam int unsigned MAXW      = 1024;
  localparam int unsigned LAW       = $clog2(MAXW);
  localparam int unsigned SETTLE    = 80;    // the longest word is a filtered pixel
  localparam int unsigned DOG_LIMIT = 3000;  // covers the long receiver hold and settles
  localparam int unsigned RX_HOLD   = 300;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [c3cf_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [c3cf_pkg::CFG_W-1:0] cfg_data_i = '0;

  c3cf_in_if  in_if ();
  c3cf_out_if out_if ();

  conv3x3_clamp_filter #(.MAX_WIDTH(MAXW)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: registers, line stores, 3x3 window, raster position
  // ---------------------------------------------------------------------------
  logic [23:0] mask_q [3];
  logic [15:0] div_q;
  logic [10:0] img_w_q;
  logic [15:0] img_h_q;
  logic [7:0]  upper_ln [MAXW];
  logic [7:0]  lower_ln [MAXW];
  logic [7:0]  win [3][3];
  int unsigned col_pos, row_pos, pend_cnt, cur_w, cur_h;

  out_word_t out_px_q [$];   // expected output words, oldest first
  int unsigned mism_cnt = 0;
  int unsigned pix_items = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int unsigned rx_hold = 0;

  function automatic logic [7:0] conv_value();
    int acc, d, q;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        acc += int'(win[r][c]) * int'($signed(mask_q[r][8*c +: 8]));
    d = int'($signed(div_q));
    if (d == 0) d = 1;      // zero divisor acts as one
    q = acc / d;            // truncates toward zero
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // One shift of the window pipeline; returns 1 when an output word falls out.
  function automatic bit shift_window(input logic [7:0] pix, output out_word_t res);
    int unsigned ic, ir, orow, ocol;
    logic [7:0] edge_px, val;
    logic [7:0] colv [3];
    bit have;
    ic = col_pos;
    ir = row_pos;
    edge_px = win[1][2];
    have = 1'b0;
    val = '0;
    orow = 0;
    ocol = 0;
    if (ic >= MAXW) ic = MAXW - 1;
    colv[0] = upper_ln[LAW'(ic)];
    colv[1] = lower_ln[LAW'(ic)];
    colv[2] = pix;
    upper_ln[LAW'(ic)] = colv[1];
    lower_ln[LAW'(ic)] = colv[2];
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
      win[r][2] = colv[r];
    end
    if (ic + 1 >= cur_w) begin
      col_pos = 0;
      row_pos = ir + 1;
    end else begin
      col_pos = ic + 1;
    end
    if (ic == 0) begin
      // right border of the row two back comes out here
      if (ir >= 2) begin
        orow = ir - 2;
        ocol = cur_w - 1;
        val = edge_px;
        have = 1'b1;
      end
    end else if (ir >= 1) begin
      orow = ir - 1;
      ocol = ic - 1;
      have = 1'b1;
      if (orow >= 1 && orow + 2 <= cur_h && ocol >= 1 && ocol + 2 <= cur_w) val = conv_value();
      else val = win[1][1];
    end
    if (!have) return 1'b0;
    res.pix = val;
    res.last = (orow == cur_h - 1) && (ocol == cur_w - 1);
    if (pend_cnt > 0) pend_cnt--;
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
      pend_cnt = 0;
    end
    return 1'b1;
  endfunction

  function automatic void filter_step(input logic op, input logic [7:0] pix);
    out_word_t res;
    // geometry is latched on the first pixel of an image
    if (op == c3cf_pkg::OP_PIXEL && row_pos == 0 && col_pos == 0 && pend_cnt == 0) begin
      cur_w = (img_w_q == 0) ? 1 : img_w_q;
      if (cur_w > MAXW) cur_w = MAXW;
      cur_h = (img_h_q == 0) ? 1 : img_h_q;
    end
    if (row_pos < cur_h) begin
      if (op != c3cf_pkg::OP_PIXEL) return;  // drain mid-image: ignored
      pend_cnt++;
      if (shift_window(pix, res)) out_px_q.push_back(res);
      return;
    end
    if (pend_cnt == 0) return;
    // flushing: pixel words act as drains, up to two shifts per word
    for (int k = 0; k < 2; k++)
      if (shift_window(8'd0, res)) begin
        out_px_q.push_back(res);
        return;
      end
  endfunction

  function automatic void predictor_reset();
    mask_q[0] = 24'h0;
    mask_q[1] = 24'h000100;
    mask_q[2] = 24'h0;
    div_q = 16'd1;
    img_w_q = 11'd1024;
    img_h_q = 16'd1024;
    for (int i = 0; i < MAXW; i++) begin
      upper_ln[i] = '0;
      lower_ln[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    pend_cnt = 0;
    cur_w = 1024;
    cur_h = 1024;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic op, input logic [7:0] pix);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.pixel_in <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    filter_step(op, pix);
  endtask

  // Drops valid, waits for every expected word, then lets the block go quiet.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (out_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [c3cf_pkg::IDX_W-1:0] idx,
                           input logic [c3cf_pkg::CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      c3cf_pkg::CFG_MASK_TOP:    mask_q[0] = data[23:0];
      c3cf_pkg::CFG_MASK_MIDDLE: mask_q[1] = data[23:0];
      c3cf_pkg::CFG_MASK_BOTTOM: mask_q[2] = data[23:0];
      c3cf_pkg::CFG_DIVISOR:     div_q = data[15:0];
      c3cf_pkg::CFG_IMG_WIDTH:   img_w_q = data[10:0];
      c3cf_pkg::CFG_IMG_HEIGHT:  img_h_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_mask(input logic [23:0] top, input logic [23:0] mid,
                          input logic [23:0] bot, input logic [15:0] dv);
    write_reg(c3cf_pkg::CFG_MASK_TOP, top);
    write_reg(c3cf_pkg::CFG_MASK_MIDDLE, mid);
    write_reg(c3cf_pkg::CFG_MASK_BOTTOM, bot);
    write_reg(c3cf_pkg::CFG_DIVISOR, {8'h00, dv});
  endtask

  task automatic set_geometry(input logic [10:0] w, input logic [15:0] h);
    write_reg(c3cf_pkg::CFG_IMG_WIDTH, {13'h0, w});
    write_reg(c3cf_pkg::CFG_IMG_HEIGHT, {8'h00, h});
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Full image: npix pixels (fixed value if fixed_px >= 0), optional drain
  // noise and a sender pause, then flush words until the image is done.
  task automatic run_image(input int unsigned npix, input int fixed_px,
                           input bit noisy, input int unsigned pause_at);
    for (int unsigned i = 0; i < npix; i++) begin
      if (pause_at != 0 && i == pause_at) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (out_px_q.size() != 0) @(posedge clk_i);
      end
      if (noisy && $urandom_range(0, 9) == 0)
        send_word(c3cf_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
      send_word(c3cf_pkg::OP_PIXEL, (fixed_px >= 0) ? fixed_px[7:0] : pick_pixel());
      pix_items++;
    end
    while (pend_cnt > 0) begin
      // a pixel word while outputs are pending acts as a drain
      if (noisy && $urandom_range(0, 3) == 0)
        send_word(c3cf_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
      else send_word(c3cf_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
    end
    if (noisy)
      repeat ($urandom_range(0, 2)) send_word(c3cf_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_word_t want;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;  // long hold-off: block fills and stalls its input
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (out_px_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("ERROR: unexpected word pix=%0d last=%0d",
                   out_if.pixel_out, out_if.last_pixel);
      end else begin
        want = out_px_q.pop_front();
        if (want.pix !== out_if.pixel_out || want.last !== out_if.last_pixel[0]) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("ERROR: mismatch exp pix=%0d last=%0d got pix=%0d last=%0d",
                     want.pix, want.last, out_if.pixel_out, out_if.last_pixel);
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  int unsigned dog_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) dog_cnt <= 0;
      else dog_cnt <= dog_cnt + 1;
      if (dog_cnt >= DOG_LIMIT) begin
        $display("conv3x3_clamp_filter verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Drain with nothing pending right after reset: no word.
  task automatic test_idle_drain();
    send_word(c3cf_pkg::OP_DRAIN, 8'hFF);
    send_word(c3cf_pkg::OP_DRAIN, 8'h00);
    wait_quiet();
  endtask

  // Saturation high and low, zero divisor, most negative divisor.
  task automatic test_clamp();
    set_geometry(11'd3, 16'd3);
    set_mask(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 16'd1);
    run_image(9, 255, 1'b0, 0);
    wait_quiet();
    set_mask(24'h808080, 24'h808080, 24'h808080, 16'h8000);
    run_image(9, 255, 1'b0, 0);
    wait_quiet();
    set_mask(24'h808080, 24'h808080, 24'h808080, 16'd1);
    run_image(9, -1, 1'b0, 0);
    wait_quiet();
    set_mask(24'h0, 24'h000100, 24'h0, 16'd0);
    run_image(9, -1, 1'b0, 0);
    wait_quiet();
  endtask

  // Images too small to filter pass through; zero width/height act as one.
  task automatic test_small_geometry();
    set_mask(24'h010101, 24'h01F801, 24'h010101, 16'hFFFF);
    set_geometry(11'd0, 16'd0);
    run_image(1, -1, 1'b1, 0);
    wait_quiet();
    set_geometry(11'd2, 16'd2);
    run_image(4, -1, 1'b1, 0);
    wait_quiet();
    set_geometry(11'd5, 16'd1);
    run_image(5, -1, 1'b1, 0);
    wait_quiet();
    set_geometry(11'd1, 16'd4);
    run_image(4, -1, 1'b1, 0);
    wait_quiet();
  endtask

  // Receiver holds off while sender streams; then sender waits mid-image.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_mask(24'hFF00FF, 24'h000800, 24'hFF00FF, 16'd4);
    set_geometry(11'd6, 16'd5);
    rx_hold = RX_HOLD;
    run_image(30, -1, 1'b0, 14);
    wait_quiet();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned stop_at, w, h;
    logic [23:0] rows [3];
    logic [15:0] dv;
    stop_at = pix_items + n_items;
    while (pix_items < stop_at) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      for (int r = 0; r < 3; r++)
        if ($urandom_range(0, 1)) rows[r] = 24'($urandom_range(0, 24'hFFFFFF));
        else
          for (int c = 0; c < 3; c++) rows[r][8*c +: 8] = 8'($urandom_range(0, 8) - 4);
      case ($urandom_range(0, 3))
        0: dv = 16'd0;
        1: dv = 16'($urandom_range(1, 16));
        2: dv = 16'(0 - $urandom_range(1, 16));
        default: dv = 16'($urandom_range(0, 16'hFFFF));
      endcase
      set_mask(rows[0], rows[1], rows[2], dv);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_geometry(11'(w), 16'(h));
      run_image(w * h, -1, 1'b1, 0);
      wait_quiet();
    end
  endtask

  // Tallest height: the image never completes, only its first rows are sent.
  task automatic test_tall_image();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_mask(24'h01FF01, 24'h7F0080, 24'hFE0102, 16'd3);
    set_geometry(11'd3, 16'hFFFF);
    for (int i = 0; i < 45; i++) send_word(c3cf_pkg::OP_PIXEL, pick_pixel());
    in_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = c3cf_pkg::OP_PIXEL;
    in_if.pixel_in = '0;
    predictor_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_drain();
    test_clamp();
    test_small_geometry();
    test_backpressure();
    test_random(500);
    test_tall_image();

    while (out_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("conv3x3_clamp_filter verification clean");
    end else begin
      $display("conv3x3_clamp_filter verification failed");
    end
    $finish;
  end

endmodule
